/* rtl/mspd_pkg.sv */
// mspd_pkg: shared types and constants for the motor speed PI / DAC control core.
// No dependencies; imported by every module of the block.
package mspd_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fixed-point constants
    localparam logic [16:0] SPEED_COEF   = 17'd44058;       // round(65536 * 1.2 / 1.785)
    localparam logic [23:0] SPEED_MAX_Q8 = 24'hFFFF00;      // 65535.0 in Q16.8
    localparam logic [25:0] NS_LIMIT     = 26'd65536000;    // 1000.0 in Q.16
    localparam logic [16:0] DAC_SLOPE    = 17'd216;         // 2.16 * 100
    localparam logic [19:0] DIV25_RECIP  = 20'd671089;      // ceil(2^24 / 25)
    localparam logic [12:0] DAC_OFFSET   = 13'd2176;
    localparam logic [12:0] DAC_MIN      = 13'd2600;
    localparam logic [12:0] DAC_MAX      = 13'd4096;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TARGET = 2'd0,
        CFG_PROP   = 2'd1,
        CFG_INTEG  = 2'd2
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_MUL,
        ST_SPD,
        ST_SUM,
        ST_PROP,
        ST_INTEG,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Multiplier operand select
    typedef enum logic [2:0] {
        SEL_SPEED,
        SEL_PROP,
        SEL_INTEG,
        SEL_SCALE,
        SEL_RECIP
    } mul_sel_t;

    // Sequencer -> datapath control
    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_speed;
        logic     ld_sum;
        logic     ld_acc_prop;
        logic     ld_acc_integ;
        logic     ld_ns;
        logic     out_load;
    } ctrl_t;

endpackage

/* rtl/mspd_mul.sv */
// mspd_mul: shared signed multiplier with a registered product.
// Depends on mspd_pkg for operand widths.
module mspd_mul
    import mspd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]   prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    // hold while disabled so the last product stays readable
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* rtl/mspd_ctrl.sv */
// mspd_ctrl: sequencer stepping one control tick through the shared multiplier.
// Depends on mspd_pkg for state and control types.
module mspd_ctrl
    import mspd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_accept,
    input  logic   out_free,
    output logic   idle,
    output ctrl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_accept) state_next = ST_SPD_MUL;
            ST_SPD_MUL: state_next = ST_SPD;
            ST_SPD:     state_next = ST_SUM;
            ST_SUM:     state_next = ST_PROP;
            ST_PROP:    state_next = ST_INTEG;
            ST_INTEG:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_SCALE;
            ST_SCALE:   state_next = ST_DIV;
            ST_DIV:     state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl  = '0;
        idle = 1'b0;
        ctl.mul_sel = SEL_SPEED;
        unique case (state_reg)
            ST_IDLE:    idle = 1'b1;
            ST_SPD_MUL: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_SPEED;
            end
            ST_SPD:     ctl.ld_speed = 1'b1;
            ST_SUM: begin
                ctl.ld_sum  = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_PROP;
            end
            ST_PROP: begin
                ctl.ld_acc_prop = 1'b1;
                ctl.mul_en      = 1'b1;
                ctl.mul_sel     = SEL_INTEG;
            end
            ST_INTEG:   ctl.ld_acc_integ = 1'b1;
            ST_CLAMP:   ctl.ld_ns = 1'b1;
            ST_SCALE: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_SCALE;
            end
            ST_DIV: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_RECIP;
            end
            ST_DONE:    ctl.out_load = out_free;
            default:    idle = 1'b0;
        endcase
    end

endmodule

/* rtl/motor_speed_pi_dac_control_core.sv */
// motor_speed_pi_dac_control_core: top level of the PI speed controller with DAC mapping.
// Depends on mspd_pkg, mspd_mul and mspd_ctrl.
//
// One input word per control tick carries the running encoder pulse count. The core
// takes the pulse delta since the previous tick (mod 2^32), scales it to rpm in Q16.8
// (saturated at 65535), forms the error against target_rpm, updates the saturating
// 32-bit error sum, computes kp*err + ki*sum + speed, limits it to 0..1000 rpm and
// maps it to a DAC code 2176 + 2.16*speed, clamped to 2600..4096. The result register
// loads at the end of the sequence, and only then can the next word be taken: every
// multiply goes through one shared 33x17 multiplier with a registered product, and
// the sequencer walks through speed scaling, error/sum update, proportional and
// integral products, limiting, slope scaling and a divide by 100*2^16 done as a
// shift and a reciprocal multiply. s_tready is high only while the sequencer is
// idle; the result sits in an output register, so a stalled m_tready holds the core
// in its last step until the previous word is taken.
// Config writes (target, kp, ki) are always accepted and must come while idle.
module motor_speed_pi_dac_control_core
    import mspd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] pulse_total
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // [12:0] dac_code, [28:13] speed_rpm,
                                    // [45:29] speed_error, [47:46] zero
);

    ctrl_t ctl;
    logic  idle;
    logic  in_accept;
    logic  out_free;

    // config registers
    logic [10:0] target_rpm_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;

    // state and working registers
    logic [31:0]        last_pulse_reg;
    logic [31:0]        delta_reg;
    logic [23:0]        speed_q8_reg;
    logic signed [24:0] err_q8_reg;
    logic signed [31:0] error_sum_reg;
    logic signed [57:0] acc_reg;
    logic [25:0]        ns_reg;

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    // combinational datapath
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod;
    logic [39:0]               spd_raw;
    logic [23:0]               speed_q8_next;
    logic signed [24:0]        err_q8_next;
    logic signed [40:0]        sum_x;
    logic signed [32:0]        sum_q;
    logic signed [31:0]        error_sum_next;
    logic signed [57:0]        acc_next;
    logic [25:0]               ns_next;
    logic [11:0]               div_q;
    logic [12:0]               dac_raw;
    logic [12:0]               dac_code;
    logic [16:0]               err_int;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    mspd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .out_free  (out_free),
        .idle      (idle),
        .ctl       (ctl)
    );

    mspd_mul u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // multiplier operand select
    always_comb begin
        unique case (ctl.mul_sel)
            SEL_SPEED: begin
                op_a = {1'b0, delta_reg};
                op_b = SPEED_COEF;
            end
            SEL_PROP: begin
                op_a = {{8{err_q8_reg[24]}}, err_q8_reg};
                op_b = {1'b0, prop_gain_reg};
            end
            SEL_INTEG: begin
                op_a = {error_sum_reg[31], error_sum_reg};
                op_b = {1'b0, integ_gain_reg};
            end
            SEL_SCALE: begin
                op_a = {7'b0, ns_reg};
                op_b = DAC_SLOPE;
            end
            SEL_RECIP: begin
                // speed*216 >> 18, then times 2^24/25
                op_a = {13'b0, DIV25_RECIP};
                op_b = {1'b0, prod[33:18]};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // speed in Q16.8, saturated; error in signed Q.8
    assign spd_raw       = prod[47:8];
    assign speed_q8_next = (spd_raw > {16'b0, SPEED_MAX_Q8}) ? SPEED_MAX_Q8 : spd_raw[23:0];
    assign err_q8_next   = $signed({6'b0, target_rpm_reg, 8'b0})
                         - $signed({1'b0, speed_q8_next});

    // error sum: (sum*256 + err) / 256 truncated toward zero, then 32-bit saturation
    assign sum_x = $signed({error_sum_reg[31], error_sum_reg, 8'b0})
                 + $signed({{16{err_q8_reg[24]}}, err_q8_reg});
    assign sum_q = $signed(sum_x[40:8])
                 + $signed({32'b0, (sum_x[40] && (sum_x[7:0] != 8'b0))});
    always_comb begin
        priority if (!sum_q[32] && sum_q[31]) begin
            error_sum_next = 32'sh7FFF_FFFF;
        end else if (sum_q[32] && !sum_q[31]) begin
            error_sum_next = 32'sh8000_0000;
        end else begin
            error_sum_next = sum_q[31:0];
        end
    end

    // requested speed accumulator, Q.16
    always_comb begin
        if (ctl.ld_acc_prop) begin
            acc_next = {{8{prod[PROD_W-1]}}, prod} + $signed({26'b0, speed_q8_reg, 8'b0});
        end else begin
            acc_next = acc_reg + $signed({prod, 8'b0});
        end
    end

    always_comb begin
        priority if (acc_reg[57]) begin
            ns_next = '0;
        end else if (acc_reg > $signed({32'b0, NS_LIMIT})) begin
            ns_next = NS_LIMIT;
        end else begin
            ns_next = acc_reg[25:0];
        end
    end

    // DAC code from floor(v / 25) with v = speed*216 >> 18
    assign div_q   = prod[35:24];
    assign dac_raw = DAC_OFFSET + {1'b0, div_q};
    always_comb begin
        priority if (dac_raw < DAC_MIN) begin
            dac_code = DAC_MIN;
        end else if (dac_raw > DAC_MAX) begin
            dac_code = DAC_MAX;
        end else begin
            dac_code = dac_raw;
        end
    end

    // integer error, truncated toward zero
    assign err_int = err_q8_reg[24:8]
                   + {16'b0, (err_q8_reg[24] && (err_q8_reg[7:0] != 8'b0))};

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_rpm_reg <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TARGET: target_rpm_reg <= cfg_data[10:0];
                CFG_PROP:   prop_gain_reg  <= cfg_data;
                CFG_INTEG:  integ_gain_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pulse_reg <= '0;
            error_sum_reg  <= '0;
        end else begin
            if (in_accept) begin
                last_pulse_reg <= s_tdata;
            end
            if (ctl.ld_sum) begin
                error_sum_reg <= error_sum_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            delta_reg <= s_tdata - last_pulse_reg;
        end
        if (ctl.ld_speed) begin
            speed_q8_reg <= speed_q8_next;
            err_q8_reg   <= err_q8_next;
        end
        if (ctl.ld_acc_prop || ctl.ld_acc_integ) begin
            acc_reg <= acc_next;
        end
        if (ctl.ld_ns) begin
            ns_reg <= ns_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_tdata_reg <= {2'b0, err_int, speed_q8_reg[23:8], dac_code};
        end
    end

    // checks
    a_dac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:0] >= DAC_MIN) && (m_tdata[12:0] <= DAC_MAX))
        else $error("dac code out of range");

    a_ns_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.mul_sel == SEL_SCALE) && ctl.mul_en |-> ns_reg <= NS_LIMIT)
        else $error("requested speed above limit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten");

    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.ld_sum |=> $stable(error_sum_reg))
        else $error("error sum changed outside its update step");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input taken while sequencer busy");

endmodule
